// File: hw/rtl/btli_pkg.sv
`timescale 1ns / 1ps
package btli_pkg;

  localparam int unsigned MaxEntries = 256;
  localparam int unsigned AddrW = $clog2(MaxEntries);
  localparam int unsigned CountW = AddrW + 1;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef struct packed {
    logic        cmd;
    logic [7:0]  entry_index;
    logic [31:0] entry_time;
    logic [31:0] entry_value;
    logic [31:0] query_time;
  } in_item_t;

  typedef struct packed {
    logic [31:0] interp_value;
    logic [7:0]  segment_used;
    logic        saturated;
  } out_item_t;

  typedef enum logic [1:0] {
    CL_WRITE,
    CL_ZERO,
    CL_SEARCH
  } item_class_t;

  typedef struct packed {
    item_class_t cls;
    in_item_t    item;
  } queue_entry_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_ZERO,
    ST_SRD,
    ST_SCMP,
    ST_F1,
    ST_F2,
    ST_PREP,
    ST_MUL,
    ST_DIV,
    ST_FIN
  } back_state_t;

endpackage

// File: hw/rtl/btli_front.sv
`timescale 1ns / 1ps
module btli_front
  import btli_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  output logic         busy,
  input  in_item_t     item,
  input  logic         pop,
  output logic         head_valid,
  output queue_entry_t head
);

  queue_entry_t q [2];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   count;
  logic         push;
  item_class_t  cls;

  // Classify on entry so the back end can branch at once.
  always_comb begin
    if (item.cmd == CMD_WRITE) begin
      cls = CL_WRITE;
    end else if (item.query_time == 32'd0) begin
      cls = CL_ZERO;
    end else begin
      cls = CL_SEARCH;
    end
  end

  assign busy       = (count == 2'd2);
  assign push       = start && !busy;
  assign head_valid = (count != 2'd0);
  assign head       = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= '{cls: cls, item: item};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop && head_valid) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop && head_valid};
    end
  end

endmodule

// File: hw/rtl/btli_back.sv
`timescale 1ns / 1ps
module btli_back
  import btli_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic [CountW-1:0] entry_count,
  input  logic              head_valid,
  input  queue_entry_t      head,
  output logic              pop,
  output logic              done,
  output out_item_t         result
);

  logic [31:0] time_mem [MaxEntries];
  logic [31:0] val_mem  [MaxEntries];
  logic [31:0] time_rd;
  logic [31:0] val_rd;

  back_state_t st;
  back_state_t st_next;

  queue_entry_t      cur;
  logic [AddrW-1:0]  k;
  logic [CountW-1:0] n_used;
  logic [CountW-1:0] lim;
  logic [31:0]       t1;
  logic [31:0]       t0;
  logic [31:0]       v1;
  logic [31:0]       v0;
  logic [32:0]       mag_dv;
  logic [32:0]       mag_den;
  logic              neg;
  logic [65:0]       prod;
  logic [64:0]       quo;
  logic [33:0]       rem;
  logic [6:0]        cnt;

  logic              mem_we;
  logic [AddrW-1:0]  t_addr;
  logic [AddrW-1:0]  v_addr;
  logic              step_on;

  logic signed [32:0] dv;
  logic signed [32:0] dt;
  logic signed [32:0] den;
  logic [33:0]        msum;
  logic [33:0]        rsh;
  logic [33:0]        rdiff;
  logic [40:0]        qc;
  logic signed [42:0] res;
  logic               res_hi;
  logic               res_lo;

  always_comb begin
    if (entry_count < CountW'(2)) begin
      n_used = CountW'(2);
    end else if (entry_count > CountW'(MaxEntries)) begin
      n_used = CountW'(MaxEntries);
    end else begin
      n_used = entry_count;
    end
    lim = n_used - CountW'(1);
  end

  assign step_on = ({1'b0, k} < lim) && (cur.item.query_time > time_rd);

  assign dv  = $signed({v1[31], v1}) - $signed({val_rd[31], val_rd});
  assign dt  = $signed({1'b0, cur.item.query_time}) - $signed({1'b0, t0});
  assign den = $signed({1'b0, t1}) - $signed({1'b0, t0});

  assign msum  = {1'b0, prod[65:33]} + (prod[0] ? {1'b0, mag_dv} : 34'd0);
  assign rsh   = {rem[32:0], quo[64]};
  assign rdiff = rsh - {1'b0, mag_den};

  assign qc  = (quo > 65'h100_0000_0000) ? 41'h100_0000_0000 : quo[40:0];
  assign res = neg ? ($signed({{11{v0[31]}}, v0}) - $signed({2'b00, qc}))
                   : ($signed({{11{v0[31]}}, v0}) + $signed({2'b00, qc}));
  assign res_hi = res > 43'sd2147483647;
  assign res_lo = res < -43'sd2147483648;

  // Next state.
  always_comb begin
    st_next = st;
    case (st)
      ST_IDLE: begin
        if (head_valid) begin
          st_next = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        case (cur.cls)
          CL_WRITE: st_next = ST_IDLE;
          CL_ZERO:  st_next = ST_ZERO;
          default:  st_next = ST_SRD;
        endcase
      end
      ST_ZERO: st_next = ST_IDLE;
      ST_SRD:  st_next = ST_SCMP;
      ST_SCMP: st_next = step_on ? ST_SRD : ST_F1;
      ST_F1:   st_next = ST_F2;
      ST_F2:   st_next = ST_PREP;
      ST_PREP: st_next = (den == 33'sd0) ? ST_IDLE : ST_MUL;
      ST_MUL:  st_next = (cnt == 7'd32) ? ST_DIV : ST_MUL;
      ST_DIV:  st_next = (cnt == 7'd64) ? ST_FIN : ST_DIV;
      ST_FIN:  st_next = ST_IDLE;
      default: st_next = ST_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    pop    = 1'b0;
    mem_we = 1'b0;
    t_addr = k;
    v_addr = k;
    case (st)
      ST_IDLE:     pop = head_valid;
      ST_DISPATCH: begin
        mem_we = (cur.cls == CL_WRITE);
        v_addr = '0;
      end
      ST_F1:       t_addr = k - AddrW'(1);
      ST_F2:       v_addr = k - AddrW'(1);
      default:     ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      time_mem[cur.item.entry_index[AddrW-1:0]] <= cur.item.entry_time;
      val_mem[cur.item.entry_index[AddrW-1:0]]  <= cur.item.entry_value;
    end
    time_rd <= time_mem[t_addr];
    val_rd  <= val_mem[v_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st   <= ST_IDLE;
      done <= 1'b0;
    end else begin
      st   <= st_next;
      done <= (st == ST_ZERO) || (st == ST_FIN) ||
              ((st == ST_PREP) && (den == 33'sd0));
    end
  end

  always_ff @(posedge clk) begin
    cnt <= cnt + 7'd1;
    case (st)
      ST_IDLE: begin
        cur <= head;
        k   <= AddrW'(1);
      end
      ST_ZERO: begin
        result <= '{interp_value: val_rd, segment_used: 8'd0, saturated: 1'b0};
      end
      ST_SCMP: begin
        t1 <= time_rd;
        if (step_on) begin
          k <= k + AddrW'(1);
        end
      end
      ST_F2: begin
        t0 <= time_rd;
        v1 <= val_rd;
      end
      ST_PREP: begin
        v0      <= val_rd;
        mag_dv  <= dv[32] ? 33'(-dv) : 33'(dv);
        mag_den <= den[32] ? 33'(-den) : 33'(den);
        prod    <= {33'd0, (dt[32] ? 33'(-dt) : 33'(dt))};
        neg     <= dv[32] ^ dt[32] ^ den[32];
        cnt     <= 7'd0;
        result  <= '{interp_value: val_rd, segment_used: 8'(k), saturated: 1'b0};
      end
      ST_MUL: begin
        prod <= {msum, prod[32:1]};
        if (cnt == 7'd32) begin
          cnt <= 7'd0;
          quo <= 65'({msum, prod[32:1]});
          rem <= 34'd0;
        end
      end
      ST_DIV: begin
        if (!rdiff[33]) begin
          rem <= rdiff;
          quo <= {quo[63:0], 1'b1};
        end else begin
          rem <= rsh;
          quo <= {quo[63:0], 1'b0};
        end
      end
      ST_FIN: begin
        result.segment_used <= 8'(k);
        if (res_hi) begin
          result.interp_value <= 32'h7fff_ffff;
          result.saturated    <= 1'b1;
        end else if (res_lo) begin
          result.interp_value <= 32'h8000_0000;
          result.saturated    <= 1'b1;
        end else begin
          result.interp_value <= res[31:0];
          result.saturated    <= 1'b0;
        end
      end
      default: ;
    endcase
  end

endmodule

// File: hw/rtl/breakpoint_table_linear_interp.sv
`timescale 1ns / 1ps
// Piecewise linear interpolation over a table of up to 256 Q16.16 breakpoints.
// Items enter on start while busy is low; a write item (cmd 0) stores one
// breakpoint and gives no result, and a query item (cmd 1) gives exactly one
// result beat, shown for a single cycle with done high, which the receiver must
// take as it comes. A two-deep queue in front lets up to two items wait while
// the back end works. A query at a nonzero time searches upward for its segment
// k, one breakpoint at a time because each table memory has one registered
// read port, then runs a shift-and-add multiply and a restoring divide. A
// query that lands on a zero-length segment skips the arithmetic. The user
// must write the entry_count register with cfg_we and cfg_wdata only while
// the block is idle; the block itself does not enforce this. It resets to 2,
// and values outside 2 to 256 are clamped.
module breakpoint_table_linear_interp
  import btli_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  in_item_t          item,
  input  logic              cfg_we,
  input  logic [CountW-1:0] cfg_wdata,
  output logic              done,
  output out_item_t         result
);

  logic              pop;
  logic              head_valid;
  queue_entry_t      head;
  logic [CountW-1:0] entry_count;

  // The entry count register; the back end clamps it to the legal range.
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= CountW'(2);
    end else if (cfg_we) begin
      entry_count <= cfg_wdata;
    end
  end

  // Front end: takes each beat, classifies it and queues it.
  btli_front u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .item       (item),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  // Back end: table memories, segment search and the interpolation arithmetic.
  btli_back u_back (
    .clk         (clk),
    .rst         (rst),
    .entry_count (entry_count),
    .head_valid  (head_valid),
    .head        (head),
    .pop         (pop),
    .done        (done),
    .result      (result)
  );

  // A clipped result sits on one of the two rails.
  assert property (@(posedge clk) disable iff (rst)
    done && result.saturated |->
      (result.interp_value == 32'h7fff_ffff || result.interp_value == 32'h8000_0000))
    else $error("saturated result is not at a rail");

  // A time-zero answer is never clipped.
  assert property (@(posedge clk) disable iff (rst)
    done && (result.segment_used == 8'd0) |-> !result.saturated)
    else $error("segment zero result marked saturated");

  // Busy and done are both low straight after reset.
  assert property (@(posedge clk) disable iff (rst) $past(rst) |-> !busy && !done)
    else $error("busy or done straight after reset");

  // Result beats cannot come in consecutive cycles.
  assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("two result beats in a row");

endmodule
